@@ rtl/debounced_multi_click_detector_assert.svh @@
// Assertion macros shared by the debounced multi-click detector.
`ifndef DEBOUNCED_MULTI_CLICK_DETECTOR_ASSERT_SVH
`define DEBOUNCED_MULTI_CLICK_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DMCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DMCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DMCD_ASSERT(lbl, prop, msg)
`define DMCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/dmcd_pkg.sv @@
// Types, register indexes and reset values of the debounced multi-click detector.
package dmcd_pkg;

  localparam int DefTimerWidth = 16;
  localparam int CfgWidth      = 16;
  localparam int CfgIdxWidth   = 2;
  localparam int CountWidth    = 4;

  localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_WINDOW_TICKS   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_CLICK_TARGET   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_MC_ENABLE      = 2'd3;

  localparam logic [15:0]           RstDebounceTicks = 16'd10;
  localparam logic [15:0]           RstWindowTicks   = 16'd500;
  localparam logic [CountWidth-1:0] RstClickTarget   = 4'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef enum logic [1:0] {
    LVL_UNDEF    = 2'd0,
    LVL_PRESSED  = 2'd1,
    LVL_RELEASED = 2'd2
  } level_e;

  typedef struct packed {
    logic func;
    logic level;
  } in_beat_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic multi_click_event;
    logic toggle_state;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]           debounce_ticks;
    logic [15:0]           window_ticks;
    logic [CountWidth-1:0] click_target;
    logic                  multi_click_enable;
  } cfg_t;

  typedef struct packed {
    logic edges_accepted;
    logic window_open;
    logic toggle_flag;
  } status_t;

endpackage

@@ rtl/dmcd_core.sv @@
// Debounce lockout, click window and toggle state, updated once per accepted beat.
module dmcd_core import dmcd_pkg::*; #(
  parameter int TIMER_WIDTH = DefTimerWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_valid_i,
  input  in_beat_t  beat_i,
  input  cfg_t      cfg_i,
  output out_beat_t result_o,
  output status_t   status_o
);

  localparam int ExtWidth = (TIMER_WIDTH > CfgWidth) ? TIMER_WIDTH : CfgWidth;

  function automatic logic [TIMER_WIDTH-1:0] load_len(input logic [CfgWidth-1:0] v);
    logic [ExtWidth-1:0] ext;
    logic [TIMER_WIDTH-1:0] res;
    ext = ExtWidth'(v);
    if (v == '0) begin
      res = TIMER_WIDTH'(1);
    end else if ((ext >> TIMER_WIDTH) != '0) begin
      res = '1;
    end else begin
      res = ext[TIMER_WIDTH-1:0];
    end
    return res;
  endfunction

  logic [TIMER_WIDTH-1:0] lockout_q, lockout_d;
  logic [TIMER_WIDTH-1:0] window_q, window_d;
  logic                   accepted_q, accepted_d;
  logic                   open_q, open_d;
  logic                   toggle_q, toggle_d;
  logic [CountWidth-1:0]  count_q, count_d;
  level_e                 prev_q, prev_d;
  logic                   clicked;
  logic [CountWidth:0]    count_inc;

  always_comb begin
    lockout_d  = lockout_q;
    window_d   = window_q;
    accepted_d = accepted_q;
    open_d     = open_q;
    toggle_d   = toggle_q;
    count_d    = count_q;
    prev_d     = prev_q;
    result_o   = '0;
    clicked    = (prev_q == LVL_PRESSED) && !beat_i.level;
    count_inc  = {1'b0, count_q} + (CountWidth+1)'(1);
    if (beat_i.func == FUNC_TICK) begin
      if (lockout_q != '0) begin
        lockout_d = lockout_q - TIMER_WIDTH'(1);
        if (lockout_d == '0) begin
          accepted_d = 1'b1;
        end
      end
      if (open_q) begin
        if (window_q != '0) begin
          window_d = window_q - TIMER_WIDTH'(1);
        end
        if (window_d == '0) begin
          if (count_q == cfg_i.click_target) begin
            result_o.multi_click_event = 1'b1;
            toggle_d = !toggle_q;
          end
          count_d = '0;
          open_d  = 1'b0;
          prev_d  = LVL_UNDEF;
        end
      end
    end else begin
      lockout_d = load_len(cfg_i.debounce_ticks);
      if (accepted_q) begin
        prev_d = beat_i.level ? LVL_PRESSED : LVL_RELEASED;
        if (clicked) begin
          if (!open_q && cfg_i.multi_click_enable) begin
            window_d = load_len(cfg_i.window_ticks);
            open_d   = 1'b1;
          end
          if (count_inc > {1'b0, cfg_i.click_target}) begin
            count_d = cfg_i.click_target;
          end else begin
            count_d = count_inc[CountWidth-1:0];
          end
        end
        result_o.press_event   = beat_i.level;
        result_o.release_event = !beat_i.level;
        accepted_d = 1'b0;
      end
    end
    result_o.toggle_state = toggle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q  <= '0;
      window_q   <= '0;
      accepted_q <= 1'b1;
      open_q     <= 1'b0;
      toggle_q   <= 1'b0;
      count_q    <= '0;
      prev_q     <= LVL_UNDEF;
    end else if (beat_valid_i) begin
      lockout_q  <= lockout_d;
      window_q   <= window_d;
      accepted_q <= accepted_d;
      open_q     <= open_d;
      toggle_q   <= toggle_d;
      count_q    <= count_d;
      prev_q     <= prev_d;
    end
  end

  assign status_o.edges_accepted = accepted_q;
  assign status_o.window_open    = open_q;
  assign status_o.toggle_flag    = toggle_q;

endmodule

@@ rtl/dmcd_out_buf.sv @@
// Two-entry result buffer that decouples the result side from the input side.
module dmcd_out_buf import dmcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_beat_t push_beat_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  out_beat_t   mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  fill_q;
  logic        pop;

  assign pop         = out_valid_o && out_ready_i;
  assign full_o      = fill_q == 2'd2;
  assign out_valid_o = fill_q != 2'd0;
  assign out_beat_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/debounced_multi_click_detector.sv @@
// Top level of the debounced multi-click detector.
// Each beat is either one timer tick or a pin edge with the button level, and every
// accepted beat yields exactly one result beat. A beat is accepted in any cycle in
// which the two-entry result buffer has room, so the sustained rate is one beat per
// clock, and each result is registered in that buffer. The input side stalls only
// when two results are waiting to be taken. Timers are TIMER_WIDTH bits wide, and
// lengths written above the timer range saturate at its maximum.
module debounced_multi_click_detector import dmcd_pkg::*; #(
  parameter int TIMER_WIDTH = DefTimerWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_beat_t               in_beat_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_beat_t              out_beat_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i
);

`include "debounced_multi_click_detector_assert.svh"

  cfg_t      cfg_q;
  out_beat_t result;
  status_t   status;
  logic      buf_full;
  logic      in_fire;

  assign in_ready_o = !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= RstDebounceTicks;
      cfg_q.window_ticks       <= RstWindowTicks;
      cfg_q.click_target       <= RstClickTarget;
      cfg_q.multi_click_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks     <= cfg_wdata_i;
        REG_WINDOW_TICKS:   cfg_q.window_ticks       <= cfg_wdata_i;
        REG_CLICK_TARGET:   cfg_q.click_target       <= cfg_wdata_i[CountWidth-1:0];
        REG_MC_ENABLE:      cfg_q.multi_click_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dmcd_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_valid_i(in_fire),
    .beat_i      (in_beat_i),
    .cfg_i       (cfg_q),
    .result_o    (result),
    .status_o    (status)
  );

  dmcd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_fire),
    .push_beat_i(result),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  `DMCD_ASSERT(a_one_edge_event, out_valid_o |-> !(out_beat_o.press_event && out_beat_o.release_event), "press and release in one result beat")
  `DMCD_ASSERT(a_window_opens_on_edge, $rose(status.window_open) |-> $past(in_fire && in_beat_i.func == FUNC_EDGE && cfg_q.multi_click_enable), "click window opened without an enabled edge")
  `DMCD_ASSERT(a_lock_on_edge, $fell(status.edges_accepted) |-> $past(in_fire && in_beat_i.func == FUNC_EDGE), "lockout started without an edge")
  `DMCD_ASSERT_ALWAYS(a_full_stalls, buf_full |-> !in_ready_o, "input accepted while result buffer is full")

endmodule
